/* rtl/krc_pkg.sv */
// Shared types, constants and helpers for the keyframe range curve block.
package krc_pkg;

  localparam int MAX_KEYS_DEF = 16;
  localparam int ENTRY_W      = 81;   // {time[16:0], low[31:0], high[31:0]}

  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [17:0] T_SAT    = 18'd131072;
  localparam logic [31:0] LOW_RST  = 32'd458752;
  localparam logic [31:0] HIGH_RST = 32'd655360;
  localparam logic [31:0] LIFE_RST = 32'd65536;
  localparam logic [5:0]  TDIV_STEPS = 6'd17;
  localparam logic [5:0]  LDIV_STEPS = 6'd33;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_MODIFY = 2'd1,
    OP_EVAL   = 2'd2,
    OP_NOP    = 2'd3
  } krc_op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_RANGE  = 3'd1,
    ST_FULL   = 3'd2,
    ST_NOSLOT = 3'd3,
    ST_BADIDX = 3'd4,
    ST_NOSEG  = 3'd5
  } krc_status_t;

  typedef enum logic [2:0] {
    WA_ZERO, WA_ONE, WA_IDX, WA_PTR, WA_PTRM1, WA_J
  } krc_wa_t;

  typedef enum logic [1:0] {
    WD_INIT0, WD_INIT1, WD_NEW, WD_COPY
  } krc_wd_t;

  typedef enum logic [3:0] {
    S_INIT0, S_INIT1, S_IDLE, S_DISP, S_TDIV, S_FETCH, S_LATCH, S_CHK,
    S_SHR, S_SHW, S_NEW, S_MUL, S_LDS, S_LDIV, S_LADD, S_FIN
  } krc_state_t;

  typedef struct packed {
    logic        load_in;
    logic        wr_en;
    krc_wa_t     wa;
    krc_wd_t     wd;
    logic        rd_en;
    logic        rd_j;
    logic        ptr_clr;
    logic        ptr_inc;
    logic        j_load;
    logic        j_dec;
    logic        held_inc;
    logic        step_regs;
    logic        tdiv_start;
    logic        div_step;
    logic        t_load;
    logic        mul;
    logic        ldiv_start;
    logic        ladd;
    logic        side;
    logic        res_copy;
    logic        st_set;
    krc_status_t st_code;
    logic        out_load;
  } krc_cmd_t;

  typedef struct packed {
    krc_op_t op;
    logic    range_bad;
    logic    idx_bad;
    logic    ptr_end;
    logic    ptr_zero;
    logic    eq1;
    logic    eq2;
    logic    ge1;
    logic    le2;
    logic    teq;
    logic    full;
    logic    j_gt_ptr;
    logic    cnt_zero;
    logic    out_free;
  } krc_flags_t;

  function automatic logic [16:0] ent_time(input logic [ENTRY_W-1:0] e);
    return e[80:64];
  endfunction

  function automatic logic [31:0] ent_low(input logic [ENTRY_W-1:0] e);
    return e[63:32];
  endfunction

  function automatic logic [31:0] ent_high(input logic [ENTRY_W-1:0] e);
    return e[31:0];
  endfunction

endpackage

/* rtl/krc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module krc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* rtl/krc_datapath.sv */
// Datapath: key table, walk registers, shared serial divider, multiplier, output register.
module krc_datapath #(
  parameter int MAX_KEYS = krc_pkg::MAX_KEYS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  krc_pkg::krc_cmd_t               cmd,
  output krc_pkg::krc_flags_t             flg,
  input  logic [1:0]                      opcode,
  input  logic [16:0]                     key_time,
  input  logic signed [31:0]              value_low,
  input  logic signed [31:0]              value_high,
  input  logic [$clog2(MAX_KEYS)-1:0]     entry_index,
  input  logic [31:0]                     age,
  input  logic                            cfg_we,
  input  logic [31:0]                     cfg_data,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [2:0]                      status,
  output logic signed [31:0]              result_low,
  output logic signed [31:0]              result_high,
  output logic [$clog2(MAX_KEYS+1)-1:0]   key_count
);
  import krc_pkg::*;

  localparam int IW = $clog2(MAX_KEYS);
  localparam int KW = $clog2(MAX_KEYS + 1);

  krc_op_t             op_q;
  logic [16:0]         kt_q;
  logic [31:0]         vl_q, vh_q, age_q, life;
  logic [IW-1:0]       idx_q;
  logic [KW-1:0]       held, ptr, j;
  logic [17:0]         t_q;
  logic [ENTRY_W-1:0]  prev, cur, rdata, wdata;
  logic [IW-1:0]       waddr, raddr;
  logic [KW-1:0]       ptr_m1, j_m1;
  logic [31:0]         rem, dvs;
  logic [32:0]         dsh, quo;
  logic [5:0]          cnt;
  logic                tsat, neg;
  logic signed [50:0]  p;
  logic [50:0]         pm;
  krc_status_t         st_q;
  logic [31:0]         res_lo, res_hi;

  logic [17:0]         x;
  logic [16:0]         t1, t2, span, dt;
  logic signed [32:0]  d_s;
  logic signed [17:0]  dt_s;
  logic [32:0]         trial, diff;
  logic                qbit;
  logic [31:0]         a_v, q_v;
  logic [31:0]         cur_v, prev_v;

  assign ptr_m1 = ptr - KW'(1);
  assign j_m1   = j - KW'(1);

  krc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_KEYS)) u_table (
    .clk  (clk),
    .we   (cmd.wr_en),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.rd_en),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    unique case (cmd.wa)
      WA_ZERO:  waddr = '0;
      WA_ONE:   waddr = IW'(1);
      WA_IDX:   waddr = idx_q;
      WA_PTR:   waddr = ptr[IW-1:0];
      WA_PTRM1: waddr = ptr_m1[IW-1:0];
      WA_J:     waddr = j[IW-1:0];
      default:  waddr = '0;
    endcase
    unique case (cmd.wd)
      WD_INIT0: wdata = {17'd0, LOW_RST, HIGH_RST};
      WD_INIT1: wdata = {ONE_Q16, LOW_RST, HIGH_RST};
      WD_NEW:   wdata = {kt_q, vl_q, vh_q};
      default:  wdata = rdata;
    endcase
  end

  assign raddr = cmd.rd_j ? j_m1[IW-1:0] : ptr[IW-1:0];

  // search key: insert time or normalised age
  assign x    = (op_q == OP_INSERT) ? {1'b0, kt_q} : t_q;
  assign t1   = ent_time(prev);
  assign t2   = ent_time(cur);
  assign span = t2 - t1;
  assign dt   = x[16:0] - t1;

  always_comb begin
    if (cmd.side) begin
      cur_v  = ent_high(cur);
      prev_v = ent_high(prev);
    end else begin
      cur_v  = ent_low(cur);
      prev_v = ent_low(prev);
    end
    d_s = $signed({cur_v[31], cur_v}) - $signed({prev_v[31], prev_v});
    a_v = prev_v;
  end

  assign dt_s  = $signed({1'b0, dt});
  assign pm    = p[50] ? 51'(-p) : p;
  assign trial = {rem, dsh[32]};
  assign diff  = trial - {1'b0, dvs};
  assign qbit  = (trial >= {1'b0, dvs});
  assign q_v   = neg ? (~quo[31:0] + 32'd1) : quo[31:0];

  always_comb begin
    flg.op        = op_q;
    flg.range_bad = (kt_q > ONE_Q16);
    flg.idx_bad   = (KW'(idx_q) >= held) || (32'(idx_q) >= 32'(MAX_KEYS));
    flg.ptr_end   = (ptr >= held);
    flg.ptr_zero  = (ptr == '0);
    flg.eq1       = (x == {1'b0, t1});
    flg.eq2       = (x == {1'b0, t2});
    flg.ge1       = (x >= {1'b0, t1});
    flg.le2       = (x <= {1'b0, t2});
    flg.teq       = (t1 == t2);
    flg.full      = (32'(held) >= 32'(MAX_KEYS));
    flg.j_gt_ptr  = (j > ptr);
    flg.cnt_zero  = (cnt == '0);
    flg.out_free  = !out_valid || out_ready;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      life      <= LIFE_RST;
      held      <= KW'(2);
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (cfg_we) begin
        life <= cfg_data;
      end
      if (cmd.held_inc) begin
        held <= held + KW'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.tdiv_start) begin
        cnt <= TDIV_STEPS;
      end else if (cmd.ldiv_start) begin
        cnt <= LDIV_STEPS;
      end else if (cmd.div_step) begin
        cnt <= cnt - 6'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q   <= krc_op_t'(opcode);
      kt_q   <= key_time;
      vl_q   <= value_low;
      vh_q   <= value_high;
      idx_q  <= entry_index;
      age_q  <= age;
      st_q   <= ST_OK;
      res_lo <= '0;
      res_hi <= '0;
    end
    if (cmd.st_set) begin
      st_q <= cmd.st_code;
    end
    if (cmd.ptr_clr) begin
      ptr <= '0;
    end else if (cmd.ptr_inc) begin
      ptr <= ptr + KW'(1);
    end
    if (cmd.j_load) begin
      j <= held;
    end else if (cmd.j_dec) begin
      j <= j_m1;
    end
    if (cmd.step_regs) begin
      prev <= cur;
      cur  <= rdata;
    end
    // divider set-up: age*65536/life, or |product|/span
    if (cmd.tdiv_start) begin
      rem  <= {1'b0, age_q[31:1]};
      dsh  <= {age_q[0], 32'd0};
      dvs  <= life;
      quo  <= '0;
      tsat <= ({1'b0, age_q} >= {life, 1'b0});
    end else if (cmd.ldiv_start) begin
      rem  <= {15'd0, pm[49:33]};
      dsh  <= pm[32:0];
      dvs  <= {15'd0, span};
      quo  <= '0;
      neg  <= p[50];
    end else if (cmd.div_step) begin
      rem  <= qbit ? diff[31:0] : trial[31:0];
      dsh  <= {dsh[31:0], 1'b0};
      quo  <= {quo[31:0], qbit};
    end
    if (cmd.t_load) begin
      t_q <= tsat ? T_SAT : quo[17:0];
    end
    if (cmd.mul) begin
      p <= 51'(d_s) * 51'(dt_s);
    end
    if (cmd.ladd) begin
      if (cmd.side) begin
        res_hi <= a_v + q_v;
      end else begin
        res_lo <= a_v + q_v;
      end
    end
    if (cmd.res_copy) begin
      res_lo <= ent_low(prev);
      res_hi <= ent_high(prev);
    end
    if (cmd.out_load) begin
      status      <= st_q;
      result_low  <= res_lo;
      result_high <= res_hi;
      key_count   <= held;
    end
  end
endmodule

/* rtl/krc_ctrl.sv */
// Controller: sequences table writes, the key walk, shifting and the dividers.
module krc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  krc_pkg::krc_flags_t flg,
  output krc_pkg::krc_cmd_t   cmd
);
  import krc_pkg::*;

  krc_state_t state, state_next;
  logic       side, side_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT0;
      side  <= 1'b0;
    end else begin
      state <= state_next;
      side  <= side_next;
    end
  end

  always_comb begin
    state_next = state;
    side_next  = side;
    cmd        = '0;
    cmd.side   = side;
    in_ready   = 1'b0;
    unique case (state)
      S_INIT0: begin
        cmd.wr_en  = 1'b1;
        cmd.wa     = WA_ZERO;
        cmd.wd     = WD_INIT0;
        state_next = S_INIT1;
      end
      S_INIT1: begin
        cmd.wr_en  = 1'b1;
        cmd.wa     = WA_ONE;
        cmd.wd     = WD_INIT1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        unique case (flg.op)
          OP_INSERT: begin
            if (flg.range_bad) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = ST_RANGE;
              state_next  = S_FIN;
            end else begin
              cmd.ptr_clr = 1'b1;
              state_next  = S_FETCH;
            end
          end
          OP_MODIFY: begin
            if (flg.idx_bad) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = ST_BADIDX;
            end else begin
              cmd.wr_en = 1'b1;
              cmd.wa    = WA_IDX;
              cmd.wd    = WD_NEW;
            end
            state_next = S_FIN;
          end
          OP_EVAL: begin
            cmd.tdiv_start = 1'b1;
            state_next     = S_TDIV;
          end
          default: state_next = S_FIN;
        endcase
      end
      S_TDIV: begin
        if (!flg.cnt_zero) begin
          cmd.div_step = 1'b1;
        end else begin
          cmd.t_load  = 1'b1;
          cmd.ptr_clr = 1'b1;
          state_next  = S_FETCH;
        end
      end
      S_FETCH: begin
        if (flg.ptr_end) begin
          cmd.st_set  = 1'b1;
          cmd.st_code = (flg.op == OP_INSERT) ? ST_NOSLOT : ST_NOSEG;
          state_next  = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_LATCH;
        end
      end
      S_LATCH: begin
        cmd.step_regs = 1'b1;
        if (flg.ptr_zero) begin
          cmd.ptr_inc = 1'b1;
          state_next  = S_FETCH;
        end else begin
          state_next = S_CHK;
        end
      end
      // prev/cur hold the segment that ends at entry ptr
      S_CHK: begin
        if (flg.op == OP_INSERT) begin
          if (flg.eq1) begin
            cmd.wr_en  = 1'b1;
            cmd.wa     = WA_PTRM1;
            cmd.wd     = WD_NEW;
            state_next = S_FIN;
          end else if (flg.eq2) begin
            cmd.wr_en  = 1'b1;
            cmd.wa     = WA_PTR;
            cmd.wd     = WD_NEW;
            state_next = S_FIN;
          end else if (flg.ge1 && flg.le2) begin
            if (flg.full) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = ST_FULL;
              state_next  = S_FIN;
            end else begin
              cmd.j_load = 1'b1;
              state_next = S_SHR;
            end
          end else begin
            cmd.ptr_inc = 1'b1;
            state_next  = S_FETCH;
          end
        end else begin
          if (flg.ge1 && flg.le2) begin
            if (flg.teq) begin
              cmd.res_copy = 1'b1;
              state_next   = S_FIN;
            end else begin
              side_next  = 1'b0;
              state_next = S_MUL;
            end
          end else begin
            cmd.ptr_inc = 1'b1;
            state_next  = S_FETCH;
          end
        end
      end
      S_SHR: begin
        if (flg.j_gt_ptr) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_j   = 1'b1;
          state_next = S_SHW;
        end else begin
          state_next = S_NEW;
        end
      end
      S_SHW: begin
        cmd.wr_en  = 1'b1;
        cmd.wa     = WA_J;
        cmd.wd     = WD_COPY;
        cmd.j_dec  = 1'b1;
        state_next = S_SHR;
      end
      S_NEW: begin
        cmd.wr_en    = 1'b1;
        cmd.wa       = WA_PTR;
        cmd.wd       = WD_NEW;
        cmd.held_inc = 1'b1;
        state_next   = S_FIN;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_LDS;
      end
      S_LDS: begin
        cmd.ldiv_start = 1'b1;
        state_next     = S_LDIV;
      end
      S_LDIV: begin
        if (!flg.cnt_zero) begin
          cmd.div_step = 1'b1;
        end else begin
          state_next = S_LADD;
        end
      end
      S_LADD: begin
        cmd.ladd = 1'b1;
        if (!side) begin
          side_next  = 1'b1;
          state_next = S_MUL;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (flg.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

/* rtl/keyframe_range_curve.sv */
// Top level of the keyframe range curve: controller, datapath and checks.
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+-------------------------------------------------
//  in      | in_valid  | in_ready  | opcode key_time value_low value_high entry_index age
//  out     | out_valid | out_ready | status result_low result_high key_count
//  cfg     | cfg_valid | cfg_ready | cfg_data (emitter life, Q16.16)
//
// One request at a time. Modify, bad index, range error and opcode 3 go straight to finish.
// Insert: fetch, latch and check per key walked (one table RAM read port), then a read
// and a write per key shifted. Evaluate: the 17-step age/life divider, a key walk,
// and a lerp for each of low and high (multiply, then 33-step divide per value).
// After reset the table RAM is loaded with the two default keys in S_INIT0 and S_INIT1.
// A waiting result in the output register stalls the next finish, not the next accept.
module keyframe_range_curve #(
  parameter int MAX_KEYS = krc_pkg::MAX_KEYS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      opcode,
  input  logic [16:0]                     key_time,
  input  logic signed [31:0]              value_low,
  input  logic signed [31:0]              value_high,
  input  logic [$clog2(MAX_KEYS)-1:0]     entry_index,
  input  logic [31:0]                     age,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      status,
  output logic signed [31:0]              result_low,
  output logic signed [31:0]              result_high,
  output logic [$clog2(MAX_KEYS+1)-1:0]   key_count,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [31:0]                     cfg_data
);
  import krc_pkg::*;

  krc_cmd_t   cmd;
  krc_flags_t flg;

  assign cfg_ready = 1'b1;

  krc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .flg     (flg),
    .cmd     (cmd)
  );

  krc_datapath #(.MAX_KEYS(MAX_KEYS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .flg        (flg),
    .opcode     (opcode),
    .key_time   (key_time),
    .value_low  (value_low),
    .value_high (value_high),
    .entry_index(entry_index),
    .age        (age),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .status     (status),
    .result_low (result_low),
    .result_high(result_high),
    .key_count  (key_count)
  );

  // one request in flight: an accept closes the input side
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a request is in flight");

  // failed requests carry zero results (non-evaluate requests do too, but only failures are checked)
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != 3'(ST_OK))) |-> (result_low == '0 && result_high == '0))
    else $error("non-zero result with error status");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(key_count) >= 32'd2 && 32'(key_count) <= 32'(MAX_KEYS)))
    else $error("key count out of range");
endmodule
